>>> sv/bgtr_pkg.sv
// Shared types, constants and glyph tables for the bitmap glyph text raster.
package bgtr_pkg;

    localparam int COORD_BITS = 12;
    localparam int DIM_BITS   = 13;
    localparam int CFG_BITS   = 13;
    localparam int COLOR_BITS = 32;
    localparam int CODE_BITS  = 8;
    localparam int EXT_BITS   = COORD_BITS + 1;
    localparam int CMP_BITS   = (EXT_BITS > DIM_BITS) ? EXT_BITS : DIM_BITS;

    localparam int GRID_ROWS  = 6;
    localparam int GRID_COLS  = 4;
    localparam int GRID_CELLS = GRID_ROWS * GRID_COLS;
    localparam int ROW_BITS   = $clog2(GRID_ROWS);
    localparam int COL_BITS   = $clog2(GRID_COLS);
    localparam int POS_BITS   = ROW_BITS + COL_BITS;

    localparam int SMALL_ROWS  = 5;
    localparam int SMALL_COLS  = 3;
    localparam int SMALL_CELLS = SMALL_ROWS * SMALL_COLS;

    localparam int ADV_BIG   = 5;
    localparam int ADV_SMALL = 4;
    localparam int CASE_FOLD = 32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(320);
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(240);

    typedef enum logic [1:0] {
        REG_SURFACE_WIDTH  = 2'd0,
        REG_SURFACE_HEIGHT = 2'd1,
        REG_FONT_SELECT    = 2'd2,
        REG_UNUSED         = 2'd3
    } reg_index_t;

    typedef enum logic {
        FONT_BIG   = 1'b0,
        FONT_SMALL = 1'b1
    } font_t;

    typedef struct packed {
        logic [CODE_BITS-1:0]         char_code;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic                         string_start;
        logic [COLOR_BITS-1:0]        color;
    } in_item_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic [COLOR_BITS-1:0] pixel_color;
        logic                  last_pixel;
    } out_item_t;

    typedef struct packed {
        logic [DIM_BITS-1:0] surface_width;
        logic [DIM_BITS-1:0] surface_height;
        font_t               font_select;
    } cfg_t;

    typedef struct packed {
        logic [GRID_CELLS-1:0]        mask;
        logic signed [COORD_BITS-1:0] pen_x;
        logic signed [COORD_BITS-1:0] pen_y;
        logic [COLOR_BITS-1:0]        color;
    } glyph_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic busy;
        logic pop;
    } bk_status_t;

    function automatic logic [GRID_CELLS-1:0] big_glyph(input logic [CODE_BITS-1:0] code);
        unique case (code)
            "A": return 24'h699F99;  "B": return 24'hE9E99E;  "C": return 24'h788896;
            "D": return 24'hE9999E;  "E": return 24'hF8E88F;  "F": return 24'hF8E888;
            "G": return 24'h78B996;  "H": return 24'h99F999;  "I": return 24'h622226;
            "J": return 24'h311196;  "K": return 24'h9ACA99;  "L": return 24'h88888F;
            "M": return 24'h9FF999;  "N": return 24'h9DFB99;  "O": return 24'h699996;
            "P": return 24'hE99E88;  "Q": return 24'h699963;  "R": return 24'hE99EA9;
            "S": return 24'h78611E;  "T": return 24'hF44444;  "U": return 24'h999996;
            "V": return 24'h999A44;  "W": return 24'h999FF9;  "X": return 24'h996699;
            "Y": return 24'h996244;  "Z": return 24'hF1248F;
            "0": return 24'h69BD96;  "1": return 24'h262227;  "2": return 24'h69168F;
            "3": return 24'hF16196;  "4": return 24'h99F111;  "5": return 24'hF8E196;
            "6": return 24'h68E996;  "7": return 24'hF12444;  "8": return 24'h696996;
            "9": return 24'h697116;
            ".": return 24'h000004;  "-": return 24'h00F000;  "+": return 24'h04E400;
            "/": return 24'h112488;  ":": return 24'h040040;  "#": return 24'h5F55F5;
            default: return '0;
        endcase
    endfunction

    function automatic logic [SMALL_CELLS-1:0] small_glyph(input logic [CODE_BITS-1:0] code);
        unique case (code)
            "A": return {3'd2, 3'd5, 3'd7, 3'd5, 3'd5};
            "B": return {3'd6, 3'd5, 3'd6, 3'd5, 3'd6};
            "C": return {3'd6, 3'd4, 3'd4, 3'd4, 3'd6};
            "D": return {3'd6, 3'd5, 3'd5, 3'd5, 3'd6};
            "E": return {3'd7, 3'd4, 3'd6, 3'd4, 3'd7};
            "F": return {3'd7, 3'd4, 3'd6, 3'd4, 3'd4};
            "G": return {3'd3, 3'd4, 3'd5, 3'd5, 3'd3};
            "H": return {3'd5, 3'd5, 3'd7, 3'd5, 3'd5};
            "I": return {3'd7, 3'd2, 3'd2, 3'd2, 3'd7};
            "J": return {3'd1, 3'd1, 3'd1, 3'd5, 3'd2};
            "K": return {3'd5, 3'd5, 3'd6, 3'd5, 3'd5};
            "L": return {3'd4, 3'd4, 3'd4, 3'd4, 3'd7};
            "M": return {3'd5, 3'd7, 3'd7, 3'd5, 3'd5};
            "N": return {3'd5, 3'd7, 3'd7, 3'd7, 3'd5};
            "O": return {3'd2, 3'd5, 3'd5, 3'd5, 3'd2};
            "P": return {3'd6, 3'd5, 3'd6, 3'd4, 3'd4};
            "Q": return {3'd2, 3'd5, 3'd5, 3'd2, 3'd1};
            "R": return {3'd6, 3'd5, 3'd6, 3'd5, 3'd5};
            "S": return {3'd7, 3'd4, 3'd7, 3'd1, 3'd7};
            "T": return {3'd7, 3'd2, 3'd2, 3'd2, 3'd2};
            "U": return {3'd5, 3'd5, 3'd5, 3'd5, 3'd7};
            "V": return {3'd5, 3'd5, 3'd5, 3'd5, 3'd2};
            "W": return {3'd5, 3'd5, 3'd7, 3'd7, 3'd5};
            "X": return {3'd5, 3'd5, 3'd2, 3'd5, 3'd5};
            "Y": return {3'd5, 3'd5, 3'd2, 3'd2, 3'd2};
            "Z": return {3'd7, 3'd1, 3'd2, 3'd4, 3'd7};
            "0": return {3'd7, 3'd5, 3'd5, 3'd5, 3'd7};
            "1": return {3'd2, 3'd6, 3'd2, 3'd2, 3'd7};
            "2": return {3'd6, 3'd1, 3'd7, 3'd4, 3'd7};
            "3": return {3'd6, 3'd1, 3'd3, 3'd1, 3'd6};
            "4": return {3'd5, 3'd5, 3'd7, 3'd1, 3'd1};
            "5": return {3'd7, 3'd4, 3'd6, 3'd1, 3'd6};
            "6": return {3'd3, 3'd4, 3'd7, 3'd5, 3'd7};
            "7": return {3'd7, 3'd1, 3'd2, 3'd2, 3'd2};
            "8": return {3'd7, 3'd5, 3'd7, 3'd5, 3'd7};
            "9": return {3'd7, 3'd5, 3'd7, 3'd1, 3'd6};
            ".": return {3'd0, 3'd0, 3'd0, 3'd0, 3'd2};
            "-": return {3'd0, 3'd0, 3'd7, 3'd0, 3'd0};
            "+": return {3'd0, 3'd2, 3'd7, 3'd2, 3'd0};
            "/": return {3'd1, 3'd1, 3'd2, 3'd4, 3'd4};
            ":": return {3'd0, 3'd2, 3'd0, 3'd2, 3'd0};
            "<": return {3'd1, 3'd2, 3'd4, 3'd2, 3'd1};
            ">": return {3'd4, 3'd2, 3'd1, 3'd2, 3'd4};
            "#": return {3'd5, 3'd7, 3'd5, 3'd7, 3'd5};
            default: return '0;
        endcase
    endfunction

    // place the 3x5 glyph on the 4x6 grid, top-left aligned
    function automatic logic [GRID_CELLS-1:0] small_to_grid(input logic [SMALL_CELLS-1:0] g);
        logic [GRID_CELLS-1:0] grid;
        grid = '0;
        for (int r = 0; r < SMALL_ROWS; r++) begin
            for (int c = 0; c < SMALL_COLS; c++) begin
                grid[GRID_CELLS-1-(r*GRID_COLS+c)] = g[SMALL_CELLS-1-(r*SMALL_COLS+c)];
            end
        end
        return grid;
    endfunction

endpackage

>>> sv/bgtr_front.sv
// Front end: pen tracking, case folding, glyph lookup and clipping into a pixel mask.
module bgtr_front
    import bgtr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_payload,
    input  cfg_t       cfg,
    input  q_status_t  q_stat,
    output logic       push,
    output glyph_job_t push_job
);

    logic signed [COORD_BITS-1:0] pen_x_reg, pen_x_next;
    logic signed [COORD_BITS-1:0] pen_y_reg, pen_y_next;
    logic signed [COORD_BITS-1:0] cur_x, cur_y;
    logic [CODE_BITS-1:0]         code;
    logic [GRID_CELLS-1:0]        grid;
    logic [GRID_COLS-1:0]         col_ok;
    logic [GRID_ROWS-1:0]         row_ok;
    logic [GRID_CELLS-1:0]        mask;
    logic [EXT_BITS-1:0]          px_sum [GRID_COLS];
    logic [EXT_BITS-1:0]          py_sum [GRID_ROWS];
    logic [EXT_BITS-1:0]          adv_sum;
    logic [EXT_BITS-1:0]          pen_max_ext;
    logic                         accept;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        cur_x = s_payload.string_start ? s_payload.start_x : pen_x_reg;
        cur_y = s_payload.string_start ? s_payload.start_y : pen_y_reg;

        code = s_payload.char_code;
        if (code >= CODE_BITS'("a") && code <= CODE_BITS'("z")) begin
            code = code - CODE_BITS'(CASE_FOLD);
        end

        if (cfg.font_select == FONT_SMALL) begin
            grid = small_to_grid(small_glyph(code));
        end else begin
            grid = big_glyph(code);
        end

        for (int c = 0; c < GRID_COLS; c++) begin
            px_sum[c] = {cur_x[COORD_BITS-1], cur_x} + EXT_BITS'(c);
            col_ok[c] = !px_sum[c][EXT_BITS-1]
                        && (CMP_BITS'(px_sum[c]) < CMP_BITS'(cfg.surface_width));
        end
        for (int r = 0; r < GRID_ROWS; r++) begin
            py_sum[r] = {cur_y[COORD_BITS-1], cur_y} + EXT_BITS'(r);
            row_ok[r] = !py_sum[r][EXT_BITS-1]
                        && (CMP_BITS'(py_sum[r]) < CMP_BITS'(cfg.surface_height));
        end
        for (int p = 0; p < GRID_CELLS; p++) begin
            mask[p] = grid[GRID_CELLS-1-p] && row_ok[p / GRID_COLS] && col_ok[p % GRID_COLS];
        end

        // advance with saturation at the largest positive coordinate
        pen_max_ext = {2'b00, {(COORD_BITS-1){1'b1}}};
        adv_sum = {cur_x[COORD_BITS-1], cur_x}
                  + ((cfg.font_select == FONT_SMALL) ? EXT_BITS'(ADV_SMALL) : EXT_BITS'(ADV_BIG));

        pen_x_next = pen_x_reg;
        pen_y_next = pen_y_reg;
        if (accept) begin
            pen_y_next = cur_y;
            if ($signed(adv_sum) > $signed(pen_max_ext)) begin
                pen_x_next = pen_max_ext[COORD_BITS-1:0];
            end else begin
                pen_x_next = adv_sum[COORD_BITS-1:0];
            end
        end

        push           = accept && (mask != '0);
        push_job.mask  = mask;
        push_job.pen_x = cur_x;
        push_job.pen_y = cur_y;
        push_job.color = s_payload.color;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_x_reg <= '0;
            pen_y_reg <= '0;
        end else begin
            pen_x_reg <= pen_x_next;
            pen_y_reg <= pen_y_next;
        end
    end

endmodule

>>> sv/bgtr_queue.sv
// Small job queue between the front end and the pixel emitter.
module bgtr_queue
    import bgtr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  glyph_job_t push_job,
    input  logic       pop,
    output glyph_job_t pop_job,
    output q_status_t  q_stat
);

    glyph_job_t             entries [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_BITS:0]     count_reg, count_next;

    always_comb begin
        q_stat.full  = (count_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
        q_stat.empty = (count_reg == '0);
        wr_ptr_next  = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next  = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next   = count_reg + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
        pop_job      = entries[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> sv/bgtr_back.sv
// Pixel emitter: walks a glyph mask in row-major order, one pixel per cycle while the output is not stalled.
module bgtr_back
    import bgtr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  q_status_t  q_stat,
    input  glyph_job_t pop_job,
    output bk_status_t bk_stat,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_payload
);

    glyph_job_t            cur_reg, cur_next;
    logic                  busy_reg, busy_next;
    out_item_t             out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;
    logic [GRID_CELLS-1:0] low_bit;
    logic [GRID_CELLS-1:0] mask_left;
    logic [POS_BITS-1:0]   pos;
    logic [COL_BITS-1:0]   col;
    logic [ROW_BITS-1:0]   row;
    logic [EXT_BITS-1:0]   px_sum, py_sum;
    logic                  load, last, pop;

    always_comb begin
        low_bit   = cur_reg.mask & (~cur_reg.mask + 1'b1);
        mask_left = cur_reg.mask & ~low_bit;
        last      = (mask_left == '0);

        pos = '0;
        for (int i = 0; i < GRID_CELLS; i++) begin
            if (low_bit[i]) begin
                pos = pos | POS_BITS'(i);
            end
        end
        col = pos[COL_BITS-1:0];
        row = pos[POS_BITS-1:COL_BITS];

        px_sum = {cur_reg.pen_x[COORD_BITS-1], cur_reg.pen_x} + EXT_BITS'(col);
        py_sum = {cur_reg.pen_y[COORD_BITS-1], cur_reg.pen_y} + EXT_BITS'(row);

        load = busy_reg && (!out_valid_reg || m_ready);
        pop  = !q_stat.empty && (!busy_reg || (load && last));

        cur_next  = cur_reg;
        busy_next = busy_reg;
        if (pop) begin
            cur_next  = pop_job;
            busy_next = 1'b1;
        end else if (load) begin
            cur_next.mask = mask_left;
            busy_next     = !last;
        end

        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (load) begin
            out_next.pixel_x     = px_sum[COORD_BITS-1:0];
            out_next.pixel_y     = py_sum[COORD_BITS-1:0];
            out_next.pixel_color = cur_reg.color;
            out_next.last_pixel  = last;
            out_valid_next       = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end

        bk_stat.busy = busy_reg;
        bk_stat.pop  = pop;
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> sv/bitmap_glyph_text_raster.sv
// Top level of the bitmap glyph text raster: configuration registers and block wiring.
//
//   channel  | direction | handshake         | payload
//   s_       | in        | s_valid / s_ready | in_item_t  (one character)
//   m_       | out       | m_valid / m_ready | out_item_t (one pixel)
//   cfg_     | in        | cfg_wr_en         | cfg_index, cfg_data
//
// A character is taken whenever the job queue is not full; it then yields one pixel
// per cycle while the output is not stalled, 0 to 24 per character, set by the emitter
// walking the glyph mask. A character with no visible pixel is not queued. A four-entry
// job queue lets the input run ahead of the emitter. Reset clears the pen, the queue and
// the output valid, and loads width 320, height 240 and the 4x6 font.
module bitmap_glyph_text_raster
    import bgtr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  in_item_t            s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output out_item_t           m_payload,
    input  logic                cfg_wr_en,
    input  reg_index_t          cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data
);

    cfg_t       cfg_reg, cfg_next;
    q_status_t  q_stat;
    bk_status_t bk_stat;
    glyph_job_t push_job, pop_job;
    logic       push;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SURFACE_WIDTH:  cfg_next.surface_width  = cfg_data[DIM_BITS-1:0];
                REG_SURFACE_HEIGHT: cfg_next.surface_height = cfg_data[DIM_BITS-1:0];
                REG_FONT_SELECT:    cfg_next.font_select    = font_t'(cfg_data[0]);
                REG_UNUSED:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.surface_width  <= WIDTH_RESET;
            cfg_reg.surface_height <= HEIGHT_RESET;
            cfg_reg.font_select    <= FONT_BIG;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    bgtr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .cfg       (cfg_reg),
        .q_stat    (q_stat),
        .push      (push),
        .push_job  (push_job)
    );

    bgtr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (bk_stat.pop),
        .pop_job  (pop_job),
        .q_stat   (q_stat)
    );

    bgtr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_stat    (q_stat),
        .pop_job   (pop_job),
        .bk_stat   (bk_stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    a_reset_clears_out: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid not cleared by reset");

    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        bk_stat.pop |-> !q_stat.empty)
        else $error("job queue popped while empty");

    a_push_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_stat.full)
        else $error("job queue pushed while full");

    a_mid_glyph_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_payload.last_pixel |-> bk_stat.busy)
        else $error("emitter idle while a glyph is unfinished");

endmodule
